// ===== src/alr_pkg.sv =====
`default_nettype none

package alr_pkg;

    // coordinate and derived datapath widths
    localparam int CW     = 32;           // coordinate width
    localparam int DW     = CW + 1;       // vertex difference / magnitude
    localparam int STEP_W = 31;           // step register width
    localparam int SQW    = 2 * CW;       // sum of squares, root radicand
    localparam int LW     = CW + 3;       // segment length
    localparam int TW     = LW + 1;       // carried plus length, quotient
    localparam int DDW    = 64;           // distance along segment, wraps mod 2^64
    localparam int PW     = DW + DDW;     // magnitude times distance
    localparam int NW     = PW + 1;       // product plus half divisor

    localparam int MAX_PER_SEGMENT = 62;
    localparam int MW   = $clog2(MAX_PER_SEGMENT + 1);
    localparam int CNTW = $clog2(NW);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(196608);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SQX,
        OP_SQY,
        OP_ROOT,
        OP_LEN,
        OP_DIVN,
        OP_SETUP,
        OP_MULX,
        OP_DIVX,
        OP_MULY,
        OP_DIVY,
        OP_EMIT_PT,
        OP_COMMIT,
        OP_EMIT_END,
        OP_EMIT_FIRST
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic len_zero;
        logic loop_done;
        logic end_needed;
        logic slot_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/alr_ctrl.sv =====
`default_nettype none

module alr_ctrl
    import alr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     is_first,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [14:0] {
        S_IDLE       = 15'b000000000000001,
        S_PREP       = 15'b000000000000010,
        S_SQX        = 15'b000000000000100,
        S_SQY        = 15'b000000000001000,
        S_ROOT       = 15'b000000000010000,
        S_LEN        = 15'b000000000100000,
        S_DIVN       = 15'b000000001000000,
        S_LOOP       = 15'b000000010000000,
        S_MULX       = 15'b000000100000000,
        S_DIVX       = 15'b000001000000000,
        S_MULY       = 15'b000010000000000,
        S_DIVY       = 15'b000100000000000,
        S_EMIT_END   = 15'b001000000000000,
        S_EMIT_FIRST = 15'b010000000000000,
        S_SPARE      = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = is_first ? S_EMIT_FIRST : S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_SQX;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_SQY;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_ROOT;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_LEN;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (stat.len_zero)
                begin
                    cmd.op     = OP_COMMIT;
                    state_next = stat.end_needed ? S_EMIT_END : S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_DIVN;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_SETUP;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (stat.loop_done)
                begin
                    cmd.op     = OP_COMMIT;
                    state_next = stat.end_needed ? S_EMIT_END : S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_MULX;
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_DIVX;
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_MULY;
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                if (!stat.busy)
                begin
                    cmd.op     = OP_DIVY;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (!stat.busy && stat.slot_free)
                begin
                    cmd.op     = OP_EMIT_PT;
                    state_next = S_LOOP;
                end
            end
            S_EMIT_END:
            begin
                if (stat.slot_free)
                begin
                    cmd.op     = OP_EMIT_END;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_FIRST:
            begin
                if (stat.slot_free)
                begin
                    cmd.op     = OP_EMIT_FIRST;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/alr_dp.sv =====
`default_nettype none

module alr_dp
    import alr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step_length_we,
    input  wire logic [STEP_W-1:0]       step_length,
    input  wire logic signed [CW-1:0]    point_x,
    input  wire logic signed [CW-1:0]    point_y,
    input  wire logic                    is_last,
    input  wire dp_cmd_t                 cmd,
    output dp_stat_t                     stat,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output logic signed [CW-1:0]         out_x,
    output logic signed [CW-1:0]         out_y,
    output logic                         run_last,
    output logic                         path_end,
    output logic                         truncated
);

    typedef enum logic [1:0] {
        MODE_MUL,
        MODE_ROOT,
        MODE_DIV
    } unit_mode_t;

    // state and control
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     prev_x_reg, prev_y_reg;
    logic [CW-1:0]     emitted_x_reg, emitted_y_reg;
    logic [STEP_W-1:0] carried_reg;
    logic              busy_reg;
    logic [CNTW-1:0]   cnt_reg;
    unit_mode_t        mode_reg;
    logic [MW-1:0]     k_reg, m_reg;
    logic              trunc_reg;
    logic              out_valid_reg;

    // payload
    logic [CW-1:0]     px_reg, py_reg;
    logic              last_reg;
    logic [DW-1:0]     dx_reg, dy_reg;
    logic [SQW-1:0]    sqx_reg;
    logic [LW-1:0]     len_reg;
    logic [DDW-1:0]    d_reg;
    logic [CW-1:0]     ox_reg;
    logic [PW-1:0]     ma_reg, acc_reg;
    logic [DDW-1:0]    mb_reg;
    logic [SQW-1:0]    rv_reg, rres_reg, rbit_reg;
    logic [NW-1:0]     num_reg;
    logic [LW-1:0]     dv_reg;
    logic [LW:0]       rem_reg;
    logic [TW-1:0]     q_reg;
    logic [CW-1:0]     out_x_reg, out_y_reg;
    logic              run_last_reg, path_end_reg, trunc_out_reg;

    logic [STEP_W-1:0] step_eff;
    logic [DW-1:0]     dx_in, dy_in, ax, ay, mx, sx, sy;
    logic [1:0]        sh;
    logic [PW-1:0]     acc_it;
    logic [SQW-1:0]    rt;
    logic              rge;
    logic [LW:0]       dsh;
    logic              dge;
    logic [CW-1:0]     ptx, pty;
    logic              pt_differs;
    logic              slot_free;
    logic              unit_start;
    logic              out_load;

    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    assign dx_in = {point_x[CW-1], point_x} - {prev_x_reg[CW-1], prev_x_reg};
    assign dy_in = {point_y[CW-1], point_y} - {prev_y_reg[CW-1], prev_y_reg};
    assign ax    = dx_reg[DW-1] ? (DW'(0) - dx_reg) : dx_reg;
    assign ay    = dy_reg[DW-1] ? (DW'(0) - dy_reg) : dy_reg;
    assign mx    = (ax > ay) ? ax : ay;
    // prescale so both magnitudes square within the radicand
    assign sh    = mx[DW-1] ? 2'd2 : (mx[DW-2] ? 2'd1 : 2'd0);
    assign sx    = ax >> sh;
    assign sy    = ay >> sh;

    assign acc_it = mb_reg[0] ? (acc_reg + ma_reg) : acc_reg;
    assign rt     = rres_reg + rbit_reg;
    assign rge    = (rv_reg >= rt);
    assign dsh    = {rem_reg[LW-1:0], num_reg[NW-1]};
    assign dge    = (dsh >= {1'b0, dv_reg});

    assign ptx = dx_reg[DW-1] ? (prev_x_reg - ox_reg) : (prev_x_reg + ox_reg);
    assign pty = dy_reg[DW-1] ? (prev_y_reg - q_reg[CW-1:0]) : (prev_y_reg + q_reg[CW-1:0]);
    assign pt_differs = (ptx != px_reg) || (pty != py_reg);

    assign slot_free = !out_valid_reg || out_ready;

    assign unit_start = (cmd.op == OP_SQX) || (cmd.op == OP_SQY) || (cmd.op == OP_ROOT)
                     || (cmd.op == OP_DIVN) || (cmd.op == OP_MULX) || (cmd.op == OP_DIVX)
                     || (cmd.op == OP_MULY) || (cmd.op == OP_DIVY);

    // a result enters the output register
    assign out_load = (cmd.op == OP_EMIT_PT) || (cmd.op == OP_EMIT_END)
                   || (cmd.op == OP_EMIT_FIRST);

    assign stat.busy       = busy_reg;
    assign stat.len_zero   = (len_reg == '0);
    assign stat.loop_done  = (k_reg == m_reg);
    assign stat.end_needed = last_reg && ((px_reg != emitted_x_reg) || (py_reg != emitted_y_reg));
    assign stat.slot_free  = slot_free;

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign run_last  = run_last_reg;
    assign path_end  = path_end_reg;
    assign truncated = trunc_out_reg;

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            emitted_x_reg <= '0;
            emitted_y_reg <= '0;
            carried_reg   <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            mode_reg      <= MODE_MUL;
            k_reg         <= '0;
            m_reg         <= '0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_length_we)
            begin
                step_reg <= step_length;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNTW'(1);
                end
            end
            case (cmd.op) inside
                OP_CAPTURE:
                begin
                    trunc_reg <= 1'b0;
                end
                OP_SQX, OP_SQY, OP_MULX, OP_MULY:
                begin
                    busy_reg <= 1'b1;
                    mode_reg <= MODE_MUL;
                    cnt_reg  <= CNTW'(DDW - 1);
                end
                OP_ROOT:
                begin
                    busy_reg <= 1'b1;
                    mode_reg <= MODE_ROOT;
                    cnt_reg  <= CNTW'(SQW / 2 - 1);
                end
                OP_DIVN, OP_DIVX, OP_DIVY:
                begin
                    busy_reg <= 1'b1;
                    mode_reg <= MODE_DIV;
                    cnt_reg  <= CNTW'(NW - 1);
                end
                OP_SETUP:
                begin
                    // quotient is the full point count, remainder the new carry
                    carried_reg <= rem_reg[STEP_W-1:0];
                    k_reg       <= '0;
                    if (q_reg > TW'(MAX_PER_SEGMENT))
                    begin
                        m_reg     <= MW'(MAX_PER_SEGMENT);
                        trunc_reg <= 1'b1;
                    end
                    else
                    begin
                        m_reg     <= q_reg[MW-1:0];
                        trunc_reg <= 1'b0;
                    end
                end
                OP_EMIT_PT:
                begin
                    emitted_x_reg <= ptx;
                    emitted_y_reg <= pty;
                    k_reg         <= k_reg + MW'(1);
                end
                OP_COMMIT:
                begin
                    prev_x_reg <= px_reg;
                    prev_y_reg <= py_reg;
                end
                OP_EMIT_END:
                begin
                    emitted_x_reg <= px_reg;
                    emitted_y_reg <= py_reg;
                end
                OP_EMIT_FIRST:
                begin
                    emitted_x_reg <= px_reg;
                    emitted_y_reg <= py_reg;
                    prev_x_reg    <= px_reg;
                    prev_y_reg    <= py_reg;
                    carried_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // shared iterative unit and payload
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            case (mode_reg)
                MODE_MUL:
                begin
                    acc_reg <= acc_it;
                    ma_reg  <= ma_reg << 1;
                    mb_reg  <= mb_reg >> 1;
                end
                MODE_ROOT:
                begin
                    if (rge)
                    begin
                        rv_reg   <= rv_reg - rt;
                        rres_reg <= (rres_reg >> 1) + rbit_reg;
                    end
                    else
                    begin
                        rres_reg <= rres_reg >> 1;
                    end
                    rbit_reg <= rbit_reg >> 2;
                end
                MODE_DIV:
                begin
                    rem_reg <= dge ? (dsh - {1'b0, dv_reg}) : dsh;
                    q_reg   <= {q_reg[TW-2:0], dge};
                    num_reg <= num_reg << 1;
                end
                default:
                begin
                end
            endcase
        end
        case (cmd.op) inside
            OP_CAPTURE:
            begin
                px_reg   <= point_x;
                py_reg   <= point_y;
                last_reg <= is_last;
                dx_reg   <= dx_in;
                dy_reg   <= dy_in;
            end
            OP_SQX:
            begin
                ma_reg  <= PW'(sx);
                mb_reg  <= DDW'(sx);
                acc_reg <= '0;
            end
            OP_SQY:
            begin
                sqx_reg <= acc_reg[SQW-1:0];
                ma_reg  <= PW'(sy);
                mb_reg  <= DDW'(sy);
                acc_reg <= '0;
            end
            OP_ROOT:
            begin
                rv_reg   <= sqx_reg + acc_reg[SQW-1:0];
                rres_reg <= '0;
                rbit_reg <= SQW'(1) << (SQW - 2);
            end
            OP_LEN:
            begin
                len_reg <= LW'(rres_reg[CW-1:0]) << sh;
            end
            OP_DIVN:
            begin
                num_reg <= NW'(TW'(carried_reg) + TW'(len_reg));
                dv_reg  <= LW'(step_eff);
                rem_reg <= '0;
                q_reg   <= '0;
            end
            OP_SETUP:
            begin
                d_reg <= DDW'(step_eff) - DDW'(carried_reg);
            end
            OP_MULX:
            begin
                ma_reg  <= PW'(ax);
                mb_reg  <= d_reg;
                acc_reg <= '0;
            end
            OP_DIVX, OP_DIVY:
            begin
                // round half away from zero on the magnitude
                num_reg <= NW'(acc_reg) + NW'(len_reg >> 1);
                dv_reg  <= len_reg;
                rem_reg <= '0;
                q_reg   <= '0;
            end
            OP_MULY:
            begin
                ox_reg  <= q_reg[CW-1:0];
                ma_reg  <= PW'(ay);
                mb_reg  <= d_reg;
                acc_reg <= '0;
            end
            OP_EMIT_PT:
            begin
                out_x_reg     <= ptx;
                out_y_reg     <= pty;
                run_last_reg  <= (k_reg == (m_reg - MW'(1))) && !(last_reg && pt_differs);
                path_end_reg  <= (k_reg == (m_reg - MW'(1))) && last_reg && !pt_differs;
                trunc_out_reg <= trunc_reg;
                d_reg         <= d_reg + DDW'(step_eff);
            end
            OP_EMIT_END:
            begin
                out_x_reg     <= px_reg;
                out_y_reg     <= py_reg;
                run_last_reg  <= 1'b1;
                path_end_reg  <= 1'b1;
                trunc_out_reg <= trunc_reg;
            end
            OP_EMIT_FIRST:
            begin
                out_x_reg     <= px_reg;
                out_y_reg     <= py_reg;
                run_last_reg  <= 1'b1;
                path_end_reg  <= last_reg;
                trunc_out_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result loaded while output register still full");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        unit_start |-> !busy_reg)
        else $error("iterative unit restarted while busy");

    a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= m_reg)
        else $error("point index ran past point count");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg)
        |-> ($past(cmd.op) == OP_EMIT_PT || $past(cmd.op) == OP_EMIT_END
             || $past(cmd.op) == OP_EMIT_FIRST))
        else $error("output valid without an emit");

endmodule

`default_nettype wire

// ===== src/polyline_arc_length_resampler.sv =====
`default_nettype none

// Polyline arc-length resampler. Vertices (signed Q16.16) come in one beat
// at a time with first/last marks; the block returns points spaced
// step_length apart along the path, carrying leftover distance across
// vertices. A first vertex is returned as is. Any other vertex first goes
// through setup: squares of the offsets on a 64-step shift-add multiplier,
// a 32-step square root and a 98-step restoring divide for the point count.
// Each spaced point then takes two multiplies and two divides on the same
// shared unit; a segment is capped at 62 points, plus one more beat for the
// true endpoint at a last vertex if that point was not already emitted.
// One vertex is worked on at a time; the next input beat is taken once all
// results of the current one are loaded into the output register, which
// holds a result while the consumer stalls.
// step_length may only be written while the block is idle.
module polyline_arc_length_resampler
    import alr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 step_length_we,
    input  wire logic [STEP_W-1:0]    step_length,
    // vertex beats
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [CW-1:0] point_x,
    input  wire logic signed [CW-1:0] point_y,
    input  wire logic                 is_first,
    input  wire logic                 is_last,
    // resampled point beats
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [CW-1:0]      out_x,
    output logic signed [CW-1:0]      out_y,
    output logic                      run_last,
    output logic                      path_end,
    output logic                      truncated
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing of the per-vertex work
    alr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_first (is_first),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // path state, shared multiply/root/divide unit and output register
    alr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_length_we (step_length_we),
        .step_length    (step_length),
        .point_x        (point_x),
        .point_y        (point_y),
        .is_last        (is_last),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_x          (out_x),
        .out_y          (out_y),
        .run_last       (run_last),
        .path_end       (path_end),
        .truncated      (truncated)
    );

endmodule

`default_nettype wire

// ===== bench/polyline_arc_length_resampler_test.sv =====
module polyline_arc_length_resampler_test;
    import alr_pkg::*;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 run_last;
        logic                 path_end;
        logic                 truncated;
    } path_point_t;

    // scoreboard: predicts the resampled points of each vertex beat and
    // checks every output beat against the oldest predicted point
    class resample_scoreboard;
        longint          prev_x, prev_y, emitted_x, emitted_y;
        longint unsigned carried, step;
        path_point_t     pending_points[$];
        int              errors;

        function new();
            prev_x = 0;
            prev_y = 0;
            emitted_x = 0;
            emitted_y = 0;
            carried = 0;
            step = 64'(STEP_RESET);
            errors = 0;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        // floor of the euclidean length, pre-scaled so the squares fit
        function longint unsigned seg_length(longint dx, longint dy);
            longint unsigned ax, ay, m, sx, sy;
            int sh;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            m = ax > ay ? ax : ay;
            sh = 0;
            while ((m >> sh) >= (64'd1 << 31))
                sh++;
            sx = ax >> sh;
            sy = ay >> sh;
            return int_root(sx * sx + sy * sy) << sh;
        endfunction

        // round(a * b / c), half away from zero, exact
        function longint unsigned scale_round(longint unsigned a, longint unsigned b,
                                              longint unsigned c);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b} + {64'd0, c >> 1};
            return 64'(p / {64'd0, c});
        endfunction

        function void note_vertex(logic signed [CW-1:0] px_in, logic signed [CW-1:0] py_in,
                                  logic first, logic last);
            path_point_t     pts[$];
            path_point_t     pt;
            longint          px, py, dx, dy;
            longint unsigned len, st, total, n, m, d, ax, ay;
            logic            trunc;
            px = px_in;
            py = py_in;
            trunc = 0;
            if (first)
            begin
                carried = 0;
                pt = '{px_in, py_in, 0, 0, 0};
                pts.insert(pts.size(), pt);
                emitted_x = px;
                emitted_y = py;
            end
            else
            begin
                dx = px - prev_x;
                dy = py - prev_y;
                len = seg_length(dx, dy);
                if (len != 0)
                begin
                    st = step != 0 ? step : 1;
                    total = carried + len;
                    n = 0;
                    ax = dx < 0 ? -dx : dx;
                    ay = dy < 0 ? -dy : dy;
                    if (total >= st)
                        n = (total - st) / st + 1;
                    m = n;
                    if (m > MAX_PER_SEGMENT)
                    begin
                        m = MAX_PER_SEGMENT;
                        trunc = 1;
                    end
                    for (longint unsigned k = 0; k < m; k++)
                    begin
                        d = st - carried + k * st;
                        emitted_x = dx < 0 ? prev_x - longint'(scale_round(ax, d, len))
                                           : prev_x + longint'(scale_round(ax, d, len));
                        emitted_y = dy < 0 ? prev_y - longint'(scale_round(ay, d, len))
                                           : prev_y + longint'(scale_round(ay, d, len));
                        pt = '{CW'(emitted_x), CW'(emitted_y), 0, 0, 0};
                        pts.insert(pts.size(), pt);
                    end
                    carried = total - n * st;
                end
            end
            prev_x = px;
            prev_y = py;
            // endpoint tolerance rounds to zero LSBs: any offset emits the vertex
            if (last && seg_length(px - emitted_x, py - emitted_y) > 0)
            begin
                pt = '{px_in, py_in, 0, 0, 0};
                pts.insert(pts.size(), pt);
                emitted_x = px;
                emitted_y = py;
            end
            foreach (pts[j])
            begin
                pts[j].truncated = trunc;
                if (j == pts.size() - 1)
                begin
                    pts[j].run_last = 1;
                    pts[j].path_end = last;
                end
                pending_points.insert(pending_points.size(), pts[j]);
            end
        endfunction

        task check_point(path_point_t got);
            path_point_t want;
            if (pending_points.size() == 0)
            begin
                report("unexpected beat out_x", got.x, 0);
            end
            else
            begin
                want = pending_points.pop_front();
                if (got.x !== want.x) report("out_x", got.x, want.x);
                if (got.y !== want.y) report("out_y", got.y, want.y);
                if (got.run_last !== want.run_last)
                    report("run_last", got.run_last, want.run_last);
                if (got.path_end !== want.path_end)
                    report("path_end", got.path_end, want.path_end);
                if (got.truncated !== want.truncated)
                    report("truncated", got.truncated, want.truncated);
            end
        endtask
    endclass

    localparam int IDLE_LIMIT   = 30000;   // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 1000;   // covers a vertex that emits nothing
    localparam int RANDOM_ITEMS = 310;

    logic                 clk;
    logic                 rst_n;
    logic                 step_length_we;
    logic [STEP_W-1:0]    step_length;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 is_first;
    logic                 is_last;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic                 run_last;
    logic                 path_end;
    logic                 truncated;

    resample_scoreboard sb;
    logic   calm;           // no idling on either side while set
    int     idle_cycles;
    longint cur_x, cur_y;   // last vertex sent, for building random paths

    polyline_arc_length_resampler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_length_we (step_length_we),
        .step_length    (step_length),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .is_first       (is_first),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_x          (out_x),
        .out_y          (out_y),
        .run_last       (run_last),
        .path_end       (path_end),
        .truncated      (truncated)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // consumer stalls about one cycle in five unless in a calm stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
            out_ready <= calm || ($urandom_range(99) >= 20);
    end

    // beat monitor: notes accepted vertices, checks accepted points, watchdog
    always @(posedge clk)
    begin
        path_point_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_vertex(point_x, point_y, is_first, is_last);
            if (out_valid && out_ready)
            begin
                got = '{out_x, out_y, run_last, path_end, truncated};
                sb.check_point(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // drive one vertex beat and hold it until taken
    task send_vertex(longint x, longint y, logic first, logic last);
        int gap;
        gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1;
        point_x  <= CW'(x);
        point_y  <= CW'(y);
        is_first <= first;
        is_last  <= last;
        cur_x = x;
        cur_y = y;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending until every predicted point has come out
    task drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending_points.size() != 0)
            @(negedge clk);
    endtask

    // register write only once the block is idle
    task write_step(logic [STEP_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        step_length_we <= 1;
        step_length    <= v;
        @(negedge clk);
        step_length_we <= 0;
        sb.step = 64'(v);
    endtask

    // random offset of roughly one step per axis, occasionally several
    function longint rand_offset(longint unsigned st, logic longer);
        longint unsigned span;
        longint          d;
        span = longer ? st * 8 : st * 2;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        d = longint'($urandom_range(0, 32'(span))) - longint'(span / 2);
        return d;
    endfunction

    function longint clamp_move(longint from, longint d);
        longint t;
        t = from + d;
        if (t > 64'sd2147483647 || t < -64'sd2147483648)
            t = from - d;
        return t;
    endfunction

    task random_vertex(logic first, logic last);
        logic   longer;
        longint nx, ny;
        longer = $urandom_range(99) < 10;
        if (first)
        begin
            nx = longint'(signed'($urandom()));
            ny = longint'(signed'($urandom()));
        end
        else
        begin
            nx = clamp_move(cur_x, rand_offset(sb.step, longer));
            ny = clamp_move(cur_y, rand_offset(sb.step, longer));
        end
        send_vertex(nx, ny, first, last);
    endtask

    initial
    begin
        logic [STEP_W-1:0] steps[5];
        int                sent, nverts;
        sb = new();
        calm = 0;
        idle_cycles = 0;
        cur_x = 0;
        cur_y = 0;
        rst_n = 0;
        step_length_we = 0;
        step_length = STEP_RESET;
        in_valid = 0;
        point_x = 0;
        point_y = 0;
        is_first = 0;
        is_last = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;

        // directed part, reset step of 3 m
        // no first mark after reset: segment starts at the origin
        send_vertex(6 * 65536, 8 * 65536, 0, 0);
        send_vertex(0, 0, 1, 0);
        send_vertex(10 * 65536, 0, 0, 0);
        // zero-length segment
        send_vertex(10 * 65536, 0, 0, 0);
        send_vertex(10 * 65536, -7 * 65536, 0, 0);
        send_vertex(-5 * 65536, -7 * 65536, 0, 1);
        // continue after a last without a new first
        send_vertex(-5 * 65536, -1 * 65536, 0, 0);
        // last that lands on an emitted point, then a last with nothing to emit
        send_vertex(0, 0, 1, 0);
        send_vertex(6 * 65536, 0, 0, 1);
        send_vertex(6 * 65536, 0, 0, 1);
        // first and last together
        send_vertex(12345, -54321, 1, 1);
        // coordinate extremes: full diagonal hits the per-segment cap
        send_vertex(-64'sd2147483648, -64'sd2147483648, 1, 0);
        send_vertex(64'sd2147483647, 64'sd2147483647, 0, 1);
        send_vertex(64'sd2147483647, -64'sd2147483648, 1, 0);
        send_vertex(-64'sd2147483648, 64'sd2147483647, 0, 0);
        send_vertex(-64'sd2147483648, 64'sd2147483647 - 65536, 0, 1);
        drain();

        // random part over several step settings, extremes included
        steps[0] = STEP_W'(6554);
        steps[1] = STEP_W'(31'h7FFF_FFFF);
        steps[2] = STEP_W'(65536);
        steps[3] = STEP_RESET;
        steps[4] = STEP_W'($urandom_range(6554, 1000000));
        sent = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_step(steps[ph]);
            while (sent < (ph + 1) * RANDOM_ITEMS / 5)
            begin
                calm = (sent >= 120 && sent < 180);
                if (sent == 200)
                    drain();
                if ($urandom_range(99) < 85)
                begin
                    // well-formed polyline
                    nverts = $urandom_range(1, 6);
                    random_vertex(1, nverts == 1 ? 1'b1 : 1'b0);
                    sent++;
                    for (int v = 1; v < nverts; v++)
                    begin
                        random_vertex(0, v == nverts - 1 ? 1'b1 : 1'b0);
                        sent++;
                    end
                end
                else
                begin
                    // stray marks: broken or continued paths
                    random_vertex($urandom_range(99) < 20, $urandom_range(1));
                    sent++;
                end
            end
        end
        calm = 0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
